[sv/wcns_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the blend function of the wrapped cosine noise sampler.
// Depends on nothing; every other file refers to it by scoped names.
package wcns_pkg;

  localparam int STORE_AW  = 14;
  localparam int VALUE_W   = 16;
  localparam int WEIGHT_W  = 17;
  localparam int CELL_W    = 10;
  localparam int FRAC_W    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam bit [63:0] PI_Q30  = 64'd3373259426;
  localparam bit [63:0] Q30_ONE = 64'd1073741824;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // One item after classification: wrapped cells and fractions for a sample,
  // entry index and value for a write.
  typedef struct packed {
    cmd_e                        cmd;
    logic [CELL_W-1:0]           x1;
    logic [CELL_W-1:0]           x2;
    logic [CELL_W-1:0]           z1;
    logic [CELL_W-1:0]           z2;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fz;
    logic [STORE_AW-1:0]         entry_index;
    logic signed [VALUE_W-1:0]   entry_value;
  } item_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } qstat_t;

  // a + floor(((b - a) * w + 2^15) / 2^16); the result lies between a and b.
  function automatic logic signed [VALUE_W-1:0] blend(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b,
    input logic [WEIGHT_W-1:0]       w
  );
    logic signed [VALUE_W:0]    diff;
    logic signed [WEIGHT_W:0]   ws;
    logic signed [34:0]         prod;
    logic signed [34:0]         q;
    diff = 17'(signed'(b)) - 17'(signed'(a));
    ws   = signed'({1'b0, w});
    prod = 35'(diff) * 35'(ws) + 35'sd32768;
    q    = prod >>> 16;
    return VALUE_W'(a + VALUE_W'(q));
  endfunction

endpackage

[sv/wcns_front.sv]
`timescale 1ns / 1ps
// Front end: accepts items, scales sample coordinates and wraps them onto the map.
// Depends on wcns_pkg.
module wcns_front #(
  parameter int MAP_WIDTH = 128,
  parameter int MAP_DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              command_i,
  input  logic [31:0]                       coord_x_i,
  input  logic [31:0]                       coord_z_i,
  input  logic [15:0]                       scale_i,
  input  logic [wcns_pkg::STORE_AW-1:0]     entry_index_i,
  input  logic signed [wcns_pkg::VALUE_W-1:0] entry_value_i,
  output logic                              push_o,
  output wcns_pkg::item_t                   item_o
);

  localparam bit [32:0] RECIP_X = 33'((64'd1 << 32) / MAP_WIDTH);
  localparam bit [32:0] RECIP_Z = 33'((64'd1 << 32) / MAP_DEPTH);
  localparam bit [10:0] W_X = 11'(MAP_WIDTH);
  localparam bit [10:0] W_Z = 11'(MAP_DEPTH);

  // Stage one: coordinate times frequency.
  logic                  v1_q;
  wcns_pkg::cmd_e        cmd1_q;
  logic [31:0]           px_q, pz_q;
  logic [wcns_pkg::STORE_AW-1:0]       idx1_q;
  logic signed [wcns_pkg::VALUE_W-1:0] val1_q;
  logic [47:0]           prod_x, prod_z;

  assign prod_x = coord_x_i * scale_i;
  assign prod_z = coord_z_i * scale_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd1_q <= wcns_pkg::cmd_e'(command_i);
      px_q   <= prod_x[47:16];
      pz_q   <= prod_z[47:16];
      idx1_q <= entry_index_i;
      val1_q <= entry_value_i;
    end
  end

  // Stage two: quotient estimate by reciprocal, off by at most one.
  logic                  v2_q;
  wcns_pkg::cmd_e        cmd2_q;
  logic [15:0]           ix_q, iz_q, qx_q, qz_q, fx_q, fz_q;
  logic [wcns_pkg::STORE_AW-1:0]       idx2_q;
  logic signed [wcns_pkg::VALUE_W-1:0] val2_q;
  logic [48:0]           rx_prod, rz_prod;

  assign rx_prod = px_q[31:16] * RECIP_X;
  assign rz_prod = pz_q[31:16] * RECIP_Z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      cmd2_q <= cmd1_q;
      ix_q   <= px_q[31:16];
      iz_q   <= pz_q[31:16];
      qx_q   <= rx_prod[47:32];
      qz_q   <= rz_prod[47:32];
      fx_q   <= px_q[15:0];
      fz_q   <= pz_q[15:0];
      idx2_q <= idx1_q;
      val2_q <= val1_q;
    end
  end

  // Stage three (combinational into the queue): remainder, correction, neighbor.
  logic [26:0] remx, remz;
  logic [11:0] rx, rz;
  logic [wcns_pkg::CELL_W-1:0] cx, cz;

  always_comb begin
    remx = {11'd0, ix_q} - 27'(qx_q) * 27'(W_X);
    remz = {11'd0, iz_q} - 27'(qz_q) * 27'(W_Z);
    rx   = remx[11:0];
    rz   = remz[11:0];
    if (rx >= 12'(W_X)) begin
      rx = rx - 12'(W_X);
    end
    if (rz >= 12'(W_Z)) begin
      rz = rz - 12'(W_Z);
    end
    cx = rx[wcns_pkg::CELL_W-1:0];
    cz = rz[wcns_pkg::CELL_W-1:0];
    item_o.cmd         = cmd2_q;
    item_o.x1          = cx;
    item_o.z1          = cz;
    item_o.x2          = (12'(cx) == 12'(W_X - 11'd1)) ? '0 : cx + 1'b1;
    item_o.z2          = (12'(cz) == 12'(W_Z - 11'd1)) ? '0 : cz + 1'b1;
    item_o.fx          = fx_q;
    item_o.fz          = fz_q;
    item_o.entry_index = idx2_q;
    item_o.entry_value = val2_q;
  end

  assign push_o = v2_q;

endmodule

[sv/wcns_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue that decouples the front end from the back end.
// Depends on wcns_pkg.
module wcns_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wcns_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            valid_o,
  output wcns_pkg::item_t item_o,
  output wcns_pkg::qstat_t stat_o
);

  wcns_pkg::item_t slot_q [wcns_pkg::QUEUE_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == 2'(wcns_pkg::QUEUE_DEPTH));

endmodule

[sv/wcns_back.sv]
`timescale 1ns / 1ps
// Back end: map store in four read copies, blend-weight table and the two blend stages.
// Depends on wcns_pkg.
module wcns_back #(
  parameter int MAP_WIDTH        = 128,
  parameter int BLEND_TABLE_SIZE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  wcns_pkg::item_t                     item_i,
  output logic                                pop_o,
  output logic                                done_o,
  output logic signed [wcns_pkg::VALUE_W-1:0] height_o
);

  localparam int TW = $clog2(BLEND_TABLE_SIZE);
  localparam bit [10:0] W_X = 11'(MAP_WIDTH);
  localparam bit [10:0] N_T = 11'(BLEND_TABLE_SIZE);
  localparam int DEPTH = 1 << wcns_pkg::STORE_AW;

  // Weight table, worked out at elaboration from the cosine series.
  logic [wcns_pkg::WEIGHT_W-1:0] wtab [BLEND_TABLE_SIZE];

  for (genvar gi = 0; gi < BLEND_TABLE_SIZE; gi++) begin : g_tab
    localparam bit        LOWER = (2 * gi <= BLEND_TABLE_SIZE);
    localparam bit [63:0] HI = LOWER ? 64'(gi) : 64'(BLEND_TABLE_SIZE - gi);
    localparam bit [63:0] T  = (wcns_pkg::PI_Q30 * HI) / BLEND_TABLE_SIZE;
    localparam bit [63:0] T2 = (T * T) >> 30;
    localparam bit [63:0] R1 = wcns_pkg::Q30_ONE - ((T2 * wcns_pkg::Q30_ONE) >> 30) / 132;
    localparam bit [63:0] R2 = wcns_pkg::Q30_ONE - ((T2 * R1) >> 30) / 90;
    localparam bit [63:0] R3 = wcns_pkg::Q30_ONE - ((T2 * R2) >> 30) / 56;
    localparam bit [63:0] R4 = wcns_pkg::Q30_ONE - ((T2 * R3) >> 30) / 30;
    localparam bit [63:0] R5 = wcns_pkg::Q30_ONE - ((T2 * R4) >> 30) / 12;
    localparam bit [63:0] V  = ((T2 * R5) >> 30) / 2;
    localparam bit [63:0] W0 = (V + 64'd16384) >> 15;
    localparam bit [63:0] WV = LOWER ? W0 : 64'd65536 - W0;
    assign wtab[gi] = wcns_pkg::WEIGHT_W'(WV);
  end

  // The back end never stalls, so it takes the queue head whenever there is one.
  assign pop_o = valid_i;

  // Addresses of the four neighbors and the weight indexes.
  logic [21:0] a11, a21, a12, a22;
  logic [26:0] tix, tiz;

  always_comb begin
    a11 = 22'(item_i.x1) + 22'(W_X) * 22'(item_i.z1);
    a21 = 22'(item_i.x2) + 22'(W_X) * 22'(item_i.z1);
    a12 = 22'(item_i.x1) + 22'(W_X) * 22'(item_i.z2);
    a22 = 22'(item_i.x2) + 22'(W_X) * 22'(item_i.z2);
    tix = item_i.fx * N_T;
    tiz = item_i.fz * N_T;
  end

  logic [wcns_pkg::VALUE_W-1:0] mem0 [DEPTH];
  logic [wcns_pkg::VALUE_W-1:0] mem1 [DEPTH];
  logic [wcns_pkg::VALUE_W-1:0] mem2 [DEPTH];
  logic [wcns_pkg::VALUE_W-1:0] mem3 [DEPTH];

  logic                  s1_q;
  logic [wcns_pkg::STORE_AW-1:0] ad0_q, ad1_q, ad2_q, ad3_q;
  logic [wcns_pkg::WEIGHT_W-1:0] wx1_q, wz1_q;
  logic                  wr_en;

  assign wr_en = valid_i && (item_i.cmd == wcns_pkg::CMD_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= valid_i && (item_i.cmd == wcns_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ad0_q <= a11[wcns_pkg::STORE_AW-1:0];
      ad1_q <= a21[wcns_pkg::STORE_AW-1:0];
      ad2_q <= a12[wcns_pkg::STORE_AW-1:0];
      ad3_q <= a22[wcns_pkg::STORE_AW-1:0];
      wx1_q <= wtab[tix[16+TW-1:16]];
      wz1_q <= wtab[tiz[16+TW-1:16]];
    end
  end

  // Each copy takes every write and serves one neighbor read.
  logic [wcns_pkg::VALUE_W-1:0] rd0_q, rd1_q, rd2_q, rd3_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem0[item_i.entry_index] <= item_i.entry_value;
      mem1[item_i.entry_index] <= item_i.entry_value;
      mem2[item_i.entry_index] <= item_i.entry_value;
      mem3[item_i.entry_index] <= item_i.entry_value;
    end
    rd0_q <= mem0[ad0_q];
    rd1_q <= mem1[ad1_q];
    rd2_q <= mem2[ad2_q];
    rd3_q <= mem3[ad3_q];
  end

  logic                  s2_q, s3_q, s4_q;
  logic [wcns_pkg::WEIGHT_W-1:0] wx2_q, wz2_q, wz3_q;
  logic signed [wcns_pkg::VALUE_W-1:0] ix1_q, ix2_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
      s3_q <= 1'b0;
      s4_q <= 1'b0;
    end else begin
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wx2_q <= wx1_q;
    wz2_q <= wz1_q;
    ix1_q <= wcns_pkg::blend(signed'(rd0_q), signed'(rd1_q), wx2_q);
    ix2_q <= wcns_pkg::blend(signed'(rd2_q), signed'(rd3_q), wx2_q);
    wz3_q <= wz2_q;
    h_q   <= wcns_pkg::blend(ix1_q, ix2_q, wz3_q);
  end

  assign done_o   = s4_q;
  assign height_o = h_q;

endmodule

[sv/wrapped_cosine_noise_sampler.sv]
`timescale 1ns / 1ps
// Top level of the wrapped cosine noise sampler: front end, queue and back end.
// Depends on wcns_pkg, wcns_front, wcns_queue and wcns_back.
//
// Usage. An item is taken at a rising edge where start is high and busy is low.
// With command_i low the item writes entry_value_i into map entry entry_index_i
// and produces no result. With command_i high the item scales coord_x_i and
// coord_z_i by scale_i, wraps them onto the map, reads the four neighbor entries
// and blends them with cosine weights, first along x and then along z.
// The result appears on height_o for exactly one cycle, marked by done_o, once the
// item has passed both front-end stages, the queue slot and the back-end address,
// read and two blend registers. The receiver cannot hold it off.
// Throughput is one item per clock while busy is low: every stage advances each
// cycle, and the map store is kept as four copies so the four neighbor reads share
// one cycle while each copy takes every write on its single write port.
// A write is seen by any sample taken on a later cycle, since all items pass
// the store in order. Map entries are undefined until written; software fills
// the map before sampling it. Reset clears all pipeline and queue control state;
// the map store is not cleared.
module wrapped_cosine_noise_sampler #(
  parameter int MAP_WIDTH        = 128,
  parameter int MAP_DEPTH        = 128,
  parameter int BLEND_TABLE_SIZE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command_i,
  input  logic [31:0]                         coord_x_i,
  input  logic [31:0]                         coord_z_i,
  input  logic [15:0]                         scale_i,
  input  logic [wcns_pkg::STORE_AW-1:0]       entry_index_i,
  input  logic signed [wcns_pkg::VALUE_W-1:0] entry_value_i,
  output logic                                done_o,
  output logic signed [wcns_pkg::VALUE_W-1:0] height_o
);

  logic             accept;
  logic             push, pop, head_valid;
  wcns_pkg::item_t  push_item, head_item;
  wcns_pkg::qstat_t qstat;

  // The back end drains the queue every cycle, so it never fills in practice.
  assign busy   = qstat.full;
  assign accept = start && !busy;

  wcns_front #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .coord_x_i     (coord_x_i),
    .coord_z_i     (coord_z_i),
    .scale_i       (scale_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .push_o        (push),
    .item_o        (push_item)
  );

  wcns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item),
    .stat_o  (qstat)
  );

  wcns_back #(
    .MAP_WIDTH        (MAP_WIDTH),
    .BLEND_TABLE_SIZE (BLEND_TABLE_SIZE)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (head_valid),
    .item_i   (head_item),
    .pop_o    (pop),
    .done_o   (done_o),
    .height_o (height_o)
  );

  // The queue holds at most one item because the back end pops every cycle.
  a_queue_shallow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= 2'd1)
    else $error("noise sampler queue holds more than one item");

  // Every result is matched by a sample item that was taken earlier.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept && (command_i == wcns_pkg::CMD_SAMPLE), 7))
    else $error("noise sampler result without a matching sample item");

  // A popped head always leaves the queue in the same cycle.
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && !push) |=> (qstat.count == 2'd0))
    else $error("noise sampler queue head was not drained");

endmodule
